// ----- hw/rtl/a85d_pkg.sv -----
// shared types and constants of the ascii85 stream decoder
`timescale 1ns / 1ps
package a85d_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int GROUP_W   = 26;  // a partial group of up to four digits stays below 85^4
   localparam int VALUE_W   = 33;  // a full or padded group stays below 85^5
   localparam int PAD_MUL_W = 20;
   localparam int DIGIT_W   = 7;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_Z     = 8'h7A;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   localparam logic [VALUE_W-1:0]   BASE       = 33'd85;
   localparam logic [GROUP_W-1:0]   LT_DIGIT   = GROUP_W'(CHAR_LT - CHAR_BANG);
   localparam logic [VALUE_W-1:0]   WORD_MAX   = 33'h0_FFFF_FFFF;
   localparam logic [2:0]           GROUP_LEN  = 3'd5;

   // multiplier for padding a partial group with the top digit
   localparam logic [PAD_MUL_W-1:0] PAD_MUL_2  = 20'd614125;
   localparam logic [PAD_MUL_W-1:0] PAD_MUL_3  = 20'd7225;
   localparam logic [PAD_MUL_W-1:0] PAD_MUL_4  = 20'd85;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       stream_done;
      logic       decode_status;
   } rsp_type;

   // one queued job for the back end: up to four bytes of a word, msb first
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        done;
      logic        status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hw/rtl/a85d_cmd_fifo.sv -----
// command queue between the decoder front end and the byte serializer
`timescale 1ns / 1ps
module a85d_cmd_fifo #(
   parameter int DEPTH = a85d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  a85d_pkg::cmd_type          push_data,
   input  logic                       pop,
   output a85d_pkg::cmd_type          pop_data,
   output a85d_pkg::queue_status_type status
);
   import a85d_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   cmd_type        mem [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign do_push  = push && !status.full;
   assign do_pop   = pop && !status.empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_ADDR) ? '0 : AW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_ADDR) ? '0 : AW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/a85d_front.sv -----
// front end: accepts text bytes, tracks marker and group state, queues byte jobs and an end-of-input status job
`timescale 1ns / 1ps
module a85d_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  a85d_pkg::req_type          req_data,
   input  a85d_pkg::queue_status_type q_status,
   output logic                       cmd_push,
   output a85d_pkg::cmd_type          cmd_data
);
   import a85d_pkg::*;

   logic [GROUP_W-1:0] group_ff, group_in;
   logic [2:0]         count_ff, count_in;
   logic               start_ff, start_in;
   logic               held_ff, held_in;
   logic               fin_ff, fin_in;
   logic               ovf_ff, ovf_in;

   logic [7:0]         c;
   logic               accept;
   logic               push_c;

   // take-byte path on a selected base state
   logic               replay;
   logic [GROUP_W-1:0] tk_group;
   logic [2:0]         tk_count;
   logic [DIGIT_W-1:0] digit;
   logic [VALUE_W-1:0] acc;
   logic [2:0]         acc_count;
   logic [GROUP_W-1:0] tk_group_nx;
   logic [2:0]         tk_count_nx;
   logic               tk_fin_nx;
   logic               tk_ovf_nx;
   logic [2:0]         tk_nbytes;
   logic [31:0]        tk_word;

   // flush path
   logic [PAD_MUL_W-1:0] pad_mul;
   logic [VALUE_W-1:0]   pad_value;
   logic                 flush_ok;

   assign c         = req_data.text_byte;
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // a held '<' that turns out not to start a marker becomes the first digit
   assign replay   = !start_ff && held_ff;
   assign tk_group = replay ? LT_DIGIT : group_ff;
   assign tk_count = replay ? 3'd1 : count_ff;
   assign digit    = DIGIT_W'(c - CHAR_BANG);
   assign acc      = VALUE_W'(VALUE_W'(tk_group) * BASE) + VALUE_W'(digit);
   assign acc_count = 3'(tk_count + 3'd1);

   always_comb begin
      tk_group_nx = tk_group;
      tk_count_nx = tk_count;
      tk_fin_nx   = fin_ff;
      tk_ovf_nx   = ovf_ff;
      tk_nbytes   = 3'd0;
      tk_word     = '0;
      priority if (fin_ff || c <= CHAR_SPACE) begin
         tk_nbytes = 3'd0;
      end else if (c == CHAR_TILDE) begin
         tk_fin_nx = 1'b1;
      end else if (c == CHAR_Z) begin
         // zero shorthand only counts at a group boundary
         if (tk_count == 3'd0) begin
            tk_nbytes = 3'd4;
         end
      end else if (c < CHAR_BANG || c > CHAR_U) begin
         tk_nbytes = 3'd0;
      end else if (acc_count == GROUP_LEN) begin
         tk_group_nx = '0;
         tk_count_nx = 3'd0;
         if (acc > WORD_MAX) begin
            tk_ovf_nx = 1'b1;
            tk_fin_nx = 1'b1;
         end else begin
            tk_nbytes = 3'd4;
            tk_word   = acc[31:0];
         end
      end else begin
         tk_group_nx = GROUP_W'(acc);
         tk_count_nx = acc_count;
      end
   end

   always_comb begin
      unique case (count_ff)
         3'd2:    pad_mul = PAD_MUL_2;
         3'd3:    pad_mul = PAD_MUL_3;
         3'd4:    pad_mul = PAD_MUL_4;
         default: pad_mul = '0;
      endcase
   end

   // pad with top digits: g * 85^m + (85^m - 1)
   assign pad_value = VALUE_W'(VALUE_W'(group_ff) * VALUE_W'(pad_mul))
                    + VALUE_W'(pad_mul) - VALUE_W'(1);
   assign flush_ok  = !ovf_ff && (count_ff >= 3'd2) && (count_ff <= 3'd4);

   always_comb begin
      group_in = group_ff;
      count_in = count_ff;
      start_in = start_ff;
      held_in  = held_ff;
      fin_in   = fin_ff;
      ovf_in   = ovf_ff;
      push_c   = 1'b0;
      cmd_data = '0;
      if (req_data.end_of_input) begin
         push_c          = 1'b1;
         cmd_data.done   = 1'b1;
         cmd_data.status = ovf_ff;
         if (flush_ok) begin
            if (pad_value > WORD_MAX) begin
               cmd_data.status = 1'b1;
            end else begin
               cmd_data.nbytes = 3'(count_ff - 3'd1);
               cmd_data.word   = pad_value[31:0];
            end
         end
         group_in = '0;
         count_in = 3'd0;
         start_in = 1'b1;
         held_in  = 1'b0;
         fin_in   = 1'b0;
         ovf_in   = 1'b0;
      end else if (start_ff && c == CHAR_LT) begin
         start_in = 1'b0;
         held_in  = 1'b1;
      end else if (replay && c == CHAR_TILDE) begin
         // start marker complete, drop both bytes
         held_in = 1'b0;
      end else begin
         start_in        = 1'b0;
         held_in         = 1'b0;
         group_in        = tk_group_nx;
         count_in        = tk_count_nx;
         fin_in          = tk_fin_nx;
         ovf_in          = tk_ovf_nx;
         push_c          = (tk_nbytes != 3'd0);
         cmd_data.nbytes = tk_nbytes;
         cmd_data.word   = tk_word;
      end
   end

   assign cmd_push = accept && push_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         count_ff <= 3'd0;
         start_ff <= 1'b1;
         held_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         group_ff <= group_in;
         count_ff <= count_in;
         start_ff <= start_in;
         held_ff  <= held_in;
         fin_ff   <= fin_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- hw/rtl/a85d_back.sv -----
// back end: turns queued jobs into result items, one byte per cycle while rsp_ready is high
`timescale 1ns / 1ps
module a85d_back (
   input  logic                       clock,
   input  logic                       reset,
   input  a85d_pkg::cmd_type          head,
   input  a85d_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output a85d_pkg::rsp_type          rsp_data
);
   import a85d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       has_byte;
   logic [7:0] sel_byte;

   assign rsp_valid = !q_status.empty;
   assign has_byte  = (head.nbytes != 3'd0);
   assign last      = !has_byte || ({1'b0, idx_ff} == 3'(head.nbytes - 3'd1));

   always_comb begin
      unique case (idx_ff)
         2'd0: sel_byte = head.word[31:24];
         2'd1: sel_byte = head.word[23:16];
         2'd2: sel_byte = head.word[15:8];
         2'd3: sel_byte = head.word[7:0];
      endcase
   end

   assign rsp_data.out_byte      = has_byte ? sel_byte : 8'd0;
   assign rsp_data.byte_valid    = has_byte;
   assign rsp_data.stream_done   = head.done && last;
   assign rsp_data.decode_status = head.done && last && head.status;

   assign pop = rsp_valid && rsp_ready && last;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && rsp_ready) begin
         idx_in = last ? 2'd0 : 2'(idx_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- hw/rtl/ascii85_stream_decoder.sv -----
// ascii85 stream decoder top level: front end, command queue, byte serializer
// a request that yields bytes has its job registered in the command queue; results come from the queue head
// throughput: one request per cycle while the command queue has room
// results leave at one per cycle while rsp_ready is high; a full group or 'z' yields four bytes from the serializer
// reset: synchronous, clears marker, group and queue state; no clearing pass
`timescale 1ns / 1ps
module ascii85_stream_decoder #(
   parameter int QUEUE_DEPTH = a85d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  a85d_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output a85d_pkg::rsp_type rsp_data
);
   import a85d_pkg::*;

   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             q_push;
   logic             q_pop;

   a85d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .cmd_push  (q_push),
      .cmd_data  (push_cmd)
   );

   a85d_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .pop       (q_pop),
      .pop_data  (head_cmd),
      .status    (q_status)
   );

   a85d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head_cmd),
      .q_status  (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // front end never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) q_status.full |-> !q_push)
      else $error("command pushed into full queue");

   // end of input always leaves a status job queued
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.end_of_input |=> !q_status.empty)
      else $error("end of input left no status job");

   // an item without a byte only ever closes a stream
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.stream_done)
      else $error("empty result item outside stream end");

endmodule
